@@ sv/iruf_pkg.sv @@
// ----------------------------------------------------------------------------
// iruf_pkg
// Shared types and constants for the IR UART frame modulator.
// ----------------------------------------------------------------------------
package iruf_pkg;

   // line frame: start bit, eight data bits, two stop bits
   localparam int unsigned FRAME_BITS  = 11;
   localparam int unsigned BYTE_BITS   = 8;
   localparam int unsigned FILL_OUT_W  = 11;
   localparam int unsigned OFFSET_W    = 4;
   localparam logic [OFFSET_W-1:0] OFFSET_START = 4'd0;
   localparam logic [OFFSET_W-1:0] OFFSET_LAST_DATA = 4'd8;
   localparam logic [OFFSET_W-1:0] OFFSET_LAST = 4'd10;

   // duty after reset: two thirds of full scale
   localparam logic [7:0] DUTY_RESET = 8'd170;

   // result queue
   localparam int unsigned RSP_DEPTH = 4;
   localparam int unsigned RSP_PTR_W = 2;
   localparam int unsigned RSP_CNT_W = 3;

   typedef enum logic {
      KIND_BYTE = 1'b0,
      KIND_TICK = 1'b1
   } kind_type;

   // classified item from front to back
   typedef struct packed {
      kind_type                kind;
      logic                    empty;
      logic                    dropped;
      logic [BYTE_BITS-1:0]    byte_value;
      logic [OFFSET_W-1:0]     offset;
      logic [FILL_OUT_W-1:0]   fill;
   } front_item_type;

   // one result item
   typedef struct packed {
      logic [7:0]              drive_duty;
      logic                    byte_dropped;
      logic [FILL_OUT_W-1:0]   fill_level;
   } rsp_item_type;

endpackage

@@ sv/iruf_front.sv @@
// ----------------------------------------------------------------------------
// iruf_front
// Accepts items, tracks bit fill, frame pointers and head bit offset.
// ----------------------------------------------------------------------------
module iruf_front
   import iruf_pkg::*;
#(
   parameter int unsigned FIFO_DEPTH  = 2048,
   parameter int unsigned FRAME_DEPTH = 256,
   parameter int unsigned FRAME_PTR_W = 8,
   parameter int unsigned FILL_W      = 11
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic                   kind,
   input  logic [7:0]             byte_value,
   output logic                   item_valid,
   output front_item_type         item,
   output logic [FRAME_PTR_W-1:0] item_frame
);

   logic [FILL_W-1:0]      fill_ff, fill_in;
   logic [FRAME_PTR_W-1:0] wr_frame_ff, wr_frame_in;
   logic [FRAME_PTR_W-1:0] rd_frame_ff, rd_frame_in;
   logic [OFFSET_W-1:0]    offset_ff, offset_in;
   logic                   valid_ff;
   front_item_type         item_ff, item_in;
   logic [FRAME_PTR_W-1:0] frame_ff, frame_in;
   logic [31:0]            fill_wide;

   // classify and update counters
   always_comb begin
      fill_in     = fill_ff;
      wr_frame_in = wr_frame_ff;
      rd_frame_in = rd_frame_ff;
      offset_in   = offset_ff;
      frame_in    = wr_frame_ff;
      item_in.kind       = kind_type'(kind);
      item_in.empty      = 1'b0;
      item_in.dropped    = 1'b0;
      item_in.byte_value = byte_value;
      item_in.offset     = offset_ff;
      if (accept) begin
         if (kind_type'(kind) == KIND_BYTE) begin
            // needs FRAME_BITS free slots with one slot kept empty
            item_in.dropped = (32'(fill_ff) + FRAME_BITS) >= FIFO_DEPTH;
            if (!item_in.dropped) begin
               fill_in = fill_ff + FILL_W'(FRAME_BITS);
               wr_frame_in = (wr_frame_ff == FRAME_PTR_W'(FRAME_DEPTH - 1)) ?
                             '0 : wr_frame_ff + 1'b1;
            end
         end else begin
            frame_in = rd_frame_ff;
            item_in.empty = (fill_ff == '0);
            if (!item_in.empty) begin
               fill_in = fill_ff - 1'b1;
               if (offset_ff == OFFSET_LAST) begin
                  offset_in = OFFSET_START;
                  rd_frame_in = (rd_frame_ff == FRAME_PTR_W'(FRAME_DEPTH - 1)) ?
                                '0 : rd_frame_ff + 1'b1;
               end else begin
                  offset_in = offset_ff + 1'b1;
               end
            end
         end
      end
      fill_wide    = 32'(fill_in);
      item_in.fill = fill_wide[FILL_OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         wr_frame_ff <= '0;
         rd_frame_ff <= '0;
         offset_ff   <= OFFSET_START;
         valid_ff    <= 1'b0;
      end else begin
         fill_ff     <= fill_in;
         wr_frame_ff <= wr_frame_in;
         rd_frame_ff <= rd_frame_in;
         offset_ff   <= offset_in;
         valid_ff    <= accept;
      end
   end

   // item register toward the back end
   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      frame_ff <= frame_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;
   assign item_frame = frame_ff;

endmodule

@@ sv/iruf_back.sv @@
// ----------------------------------------------------------------------------
// iruf_back
// Frame byte store, bit selection and carrier duty generation.
// ----------------------------------------------------------------------------
module iruf_back
   import iruf_pkg::*;
#(
   parameter int unsigned FRAME_DEPTH = 256,
   parameter int unsigned FRAME_PTR_W = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [7:0]             csr_write_data,
   input  logic                   item_valid,
   input  front_item_type         item,
   input  logic [FRAME_PTR_W-1:0] item_frame,
   output logic                   busy,
   output logic                   rsp_valid,
   output rsp_item_type           rsp_item
);

   logic [7:0]     frame_mem [FRAME_DEPTH];
   logic [7:0]     rd_data_ff;
   logic           s2_valid_ff;
   front_item_type s2_item_ff;
   logic [7:0]     carrier_duty_ff;
   logic [7:0]     duty_hold_ff, duty_hold_in;
   logic           carrier_on;
   logic [OFFSET_W-1:0] data_index;

   // byte store: write on kept bytes, registered read for ticks
   always_ff @(posedge clock) begin
      if (item_valid && item.kind == KIND_BYTE && !item.dropped) begin
         frame_mem[item_frame] <= item.byte_value;
      end
      rd_data_ff <= frame_mem[item_frame];
      s2_item_ff <= item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff     <= 1'b0;
         carrier_duty_ff <= DUTY_RESET;
         duty_hold_ff    <= '0;
      end else begin
         s2_valid_ff  <= item_valid;
         duty_hold_ff <= duty_hold_in;
         if (csr_write_enable) begin
            carrier_duty_ff <= csr_write_data;
         end
      end
   end

   // stored level: start bit on, data bits inverted, stop bits off
   always_comb begin
      data_index = s2_item_ff.offset - 1'b1;
      if (s2_item_ff.offset == OFFSET_START) begin
         carrier_on = 1'b1;
      end else if (s2_item_ff.offset <= OFFSET_LAST_DATA) begin
         carrier_on = ~rd_data_ff[data_index[2:0]];
      end else begin
         carrier_on = 1'b0;
      end
   end

   // duty update on ticks, held otherwise
   always_comb begin
      duty_hold_in = duty_hold_ff;
      if (s2_valid_ff && s2_item_ff.kind == KIND_TICK) begin
         if (s2_item_ff.empty || !carrier_on) begin
            duty_hold_in = '0;
         end else begin
            duty_hold_in = carrier_duty_ff;
         end
      end
   end

   assign busy                  = s2_valid_ff;
   assign rsp_valid             = s2_valid_ff;
   assign rsp_item.drive_duty   = duty_hold_in;
   assign rsp_item.byte_dropped = s2_item_ff.dropped;
   assign rsp_item.fill_level   = s2_item_ff.fill;

endmodule

@@ sv/iruf_rsp_fifo.sv @@
// ----------------------------------------------------------------------------
// iruf_rsp_fifo
// Small result queue that decouples the pipeline from the consumer.
// ----------------------------------------------------------------------------
module iruf_rsp_fifo
   import iruf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rsp_item_type         push_item,
   input  logic                 pop,
   output logic                 empty,
   output rsp_item_type         head_item,
   output logic [RSP_CNT_W-1:0] count
);

   rsp_item_type         slot_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic                 do_pop;

   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      count_in = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign empty     = (count_ff == '0);
   assign head_item = slot_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

@@ sv/ir_uart_frame_bit_fifo_modulator.sv @@
// Path: an item passes the front item register, then the back stage register, then
// enters the result queue. Throughput: one item per cycle while full is low, set by the
// fill and pointer update in the front end; the 4-entry result queue absorbs consumer stalls.
// Reset: synchronous, active high; counters, pointers and duty clear at once,
// carrier duty returns to 170; the frame byte store needs no clearing pass.
// ----------------------------------------------------------------------------
// ir_uart_frame_bit_fifo_modulator
// Frames bytes as UART 8N2 and gates an IR carrier duty one bit per tick.
// ----------------------------------------------------------------------------
module ir_uart_frame_bit_fifo_modulator
   import iruf_pkg::*;
#(
   parameter int unsigned FIFO_DEPTH = 2048
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic                  req_kind,
   input  logic [7:0]            req_byte_value,
   output logic                  empty,
   input  logic                  pop,
   output logic [7:0]            rsp_drive_duty,
   output logic                  rsp_byte_dropped,
   output logic [FILL_OUT_W-1:0] rsp_fill_level,
   input  logic                  csr_write_enable,
   input  logic [7:0]            csr_write_data
);

   // one byte slot per frame covers the most frames the bit queue can hold
   localparam int unsigned FRAME_DEPTH = (FIFO_DEPTH + 7) / 8;
   localparam int unsigned FRAME_PTR_W = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
   localparam int unsigned FILL_W      = $clog2(FIFO_DEPTH);

   logic                   accept;
   logic                   s1_valid;
   front_item_type         s1_item;
   logic [FRAME_PTR_W-1:0] s1_frame;
   logic                   s2_busy;
   logic                   rsp_valid;
   rsp_item_type           rsp_item;
   rsp_item_type           head_item;
   logic [RSP_CNT_W-1:0]   rsp_count;
   logic [RSP_CNT_W:0]     credit_used;

   // items in flight plus queued results must fit the result queue
   assign credit_used = {1'b0, rsp_count} + (RSP_CNT_W + 1)'(s1_valid)
                        + (RSP_CNT_W + 1)'(s2_busy);
   assign full   = credit_used >= (RSP_CNT_W + 1)'(RSP_DEPTH);
   assign accept = push && !full;

   iruf_front #(
      .FIFO_DEPTH  (FIFO_DEPTH),
      .FRAME_DEPTH (FRAME_DEPTH),
      .FRAME_PTR_W (FRAME_PTR_W),
      .FILL_W      (FILL_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .kind       (req_kind),
      .byte_value (req_byte_value),
      .item_valid (s1_valid),
      .item       (s1_item),
      .item_frame (s1_frame)
   );

   iruf_back #(
      .FRAME_DEPTH (FRAME_DEPTH),
      .FRAME_PTR_W (FRAME_PTR_W)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .item_valid       (s1_valid),
      .item             (s1_item),
      .item_frame       (s1_frame),
      .busy             (s2_busy),
      .rsp_valid        (rsp_valid),
      .rsp_item         (rsp_item)
   );

   iruf_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_valid),
      .push_item (rsp_item),
      .pop       (pop),
      .empty     (empty),
      .head_item (head_item),
      .count     (rsp_count)
   );

   assign rsp_drive_duty   = head_item.drive_duty;
   assign rsp_byte_dropped = head_item.byte_dropped;
   assign rsp_fill_level   = head_item.fill_level;

endmodule
